### src/complex_accumulator_alu_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex accumulator ALU.
// Each macro is one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ACCUMULATOR_ALU_UNIT_DEFINES_SVH
`define COMPLEX_ACCUMULATOR_ALU_UNIT_DEFINES_SVH

// Clocked implication, disabled during reset
`define CAA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked implication into the next cycle, disabled during reset
`define CAA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/caa_pkg.sv
// ----------------------------------------------------------------------------
// caa_pkg
// Shared types and constants of the complex accumulator ALU.
// ----------------------------------------------------------------------------
package caa_pkg;

    localparam int unsigned DATA_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF  = 16;
    localparam int unsigned EXP_WIDTH_DEF  = 8;
    localparam int unsigned ACTION_WIDTH   = 3;

    // Command codes
    localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_ADD   = 3'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_SUB   = 3'd2;
    localparam logic [ACTION_WIDTH-1:0] ACT_MUL   = 3'd3;
    localparam logic [ACTION_WIDTH-1:0] ACT_CONJ  = 3'd4;
    localparam logic [ACTION_WIDTH-1:0] ACT_POW   = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_FIX,
        ST_DONE
    } caa_state_t;

endpackage

### src/complex_accumulator_alu_unit.sv
// ----------------------------------------------------------------------------
// complex_accumulator_alu_unit
// Complex Q16.16 accumulator: clear, add, sub, multiply, conjugate, power.
// ----------------------------------------------------------------------------
// Each beat takes one command and returns one beat with the new accumulator.
// Clear, add, subtract, conjugate, invalid codes and powers 0 or 1 go from
// idle straight to the done state, which registers the result once the output
// is free, and the next command can be taken once the sequencer is back in
// idle. A multiply runs four real products through one shift-and-add multiplier
// that consumes one operand bit per cycle, and power n repeats the complex
// multiply n-1 times. The serial multiplier sets the rate. A new command is
// taken only once the previous result has left the output or leaves it in
// the same cycle.
// ----------------------------------------------------------------------------
`include "complex_accumulator_alu_unit_defines.svh"

module complex_accumulator_alu_unit
    import caa_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
    parameter int unsigned EXP_WIDTH  = EXP_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ACTION_WIDTH-1:0]       action,
    input  logic signed [DATA_WIDTH-1:0]  operand_real,
    input  logic signed [DATA_WIDTH-1:0]  operand_imag,
    input  logic [EXP_WIDTH-1:0]          exponent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  value_real,
    output logic signed [DATA_WIDTH-1:0]  value_imag,
    output logic                          bad_command,
    output logic                          saturated
);

    localparam int unsigned DW  = DATA_WIDTH;
    localparam int unsigned PW  = 2 * DW + 2;           // product sum width
    localparam int unsigned CW  = $clog2(DW + 1);
    localparam logic signed [PW-1:0] MAXV = PW'((65'sd1 <<< (DW - 1)) - 1);
    localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);

    caa_state_t state_reg, state_next;

    logic signed [DW-1:0] acc_re_reg, acc_im_reg;
    logic signed [DW-1:0] op_re_reg, op_im_reg;       // multiplier b operand
    logic [EXP_WIDTH-1:0] cnt_reg;                     // remaining multiplies
    logic                 sat_reg;
    logic [1:0]           prod_reg;                    // which of 4 products
    logic [CW-1:0]        bit_reg;
    logic signed [PW-1:0] sum_reg;                     // product accumulator
    logic signed [PW-1:0] part_reg;                    // shifted multiplicand
    logic [DW-1:0]        mbits_reg;                   // multiplier bits
    logic signed [DW-1:0] pr_re_reg;                   // finished real part
    logic                 ov_reg;
    logic signed [DW-1:0] res_re_reg, res_im_reg;
    logic                 res_bad_reg, res_sat_reg;

    // Command beat accepted only while the sequencer is idle and the output is free
    logic in_fire, out_fire;
    assign in_ready = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = ov_reg && out_ready;

    assign out_valid   = ov_reg;
    assign value_real  = res_re_reg;
    assign value_imag  = res_im_reg;
    assign bad_command = res_bad_reg;
    assign saturated   = res_sat_reg;

    // Saturate a wide value to DW bits
    function automatic logic signed [DW-1:0] sat_fn(input logic signed [PW-1:0] v,
                                                    output logic s);
        begin
            s = 1'b0;
            if (v > MAXV) begin s = 1'b1; sat_fn = MAXV[DW-1:0]; end
            else if (v < MINV) begin s = 1'b1; sat_fn = MINV[DW-1:0]; end
            else sat_fn = v[DW-1:0];
        end
    endfunction

    // Operand pair for product k: re = a*c - b*d, im = a*d + b*c
    // In the fix cycle the pair of the following product is loaded
    logic [1:0]           prod_sel;
    logic signed [DW-1:0] mcand, mplier;
    assign prod_sel = (state_reg == ST_FIX) ? prod_reg + 2'd1 : prod_reg;
    always_comb
    begin
        case (prod_sel)
            2'd0:    begin mcand = acc_re_reg; mplier = op_re_reg; end
            2'd1:    begin mcand = acc_im_reg; mplier = op_im_reg; end
            2'd2:    begin mcand = acc_re_reg; mplier = op_im_reg; end
            default: begin mcand = acc_im_reg; mplier = op_re_reg; end
        endcase
    end

    // Serial step: add or subtract (top bit weight negative) partial product
    logic signed [PW-1:0] step_sum;
    logic                 last_bit;
    logic                 neg_prod;
    assign last_bit = (bit_reg == CW'(DW - 1));
    assign neg_prod = (prod_reg == 2'd1);
    always_comb
    begin
        step_sum = sum_reg;
        if (mbits_reg[0])
        begin
            if (last_bit ^ neg_prod)
                step_sum = sum_reg - part_reg;
            else
                step_sum = sum_reg + part_reg;
        end
    end

    // Result of finished sum: floor shift then saturate
    logic signed [PW-1:0] shifted;
    logic signed [DW-1:0] fix_val;
    logic                 fix_sat;
    assign shifted = step_sum >>> FRAC_BITS;
    always_comb
    begin
        fix_val = sat_fn(shifted, fix_sat);
    end

    // Results of the commands that skip the multiplier
    logic signed [DW-1:0] q_re, q_im;
    logic                 q_sat, q_bad, s1, s2;
    logic                 q_mul;
    logic signed [PW-1:0] one_v;
    always_comb
    begin
        q_re = acc_re_reg; q_im = acc_im_reg;
        q_sat = 1'b0; q_bad = 1'b0; q_mul = 1'b0; s1 = 1'b0; s2 = 1'b0;
        one_v = PW'(1) <<< FRAC_BITS;
        case (action)
            ACT_CLEAR: begin q_re = '0; q_im = '0; end
            ACT_ADD:
            begin
                q_re = sat_fn(PW'(acc_re_reg) + PW'(operand_real), s1);
                q_im = sat_fn(PW'(acc_im_reg) + PW'(operand_imag), s2);
                q_sat = s1 | s2;
            end
            ACT_SUB:
            begin
                q_re = sat_fn(PW'(acc_re_reg) - PW'(operand_real), s1);
                q_im = sat_fn(PW'(acc_im_reg) - PW'(operand_imag), s2);
                q_sat = s1 | s2;
            end
            ACT_MUL: q_mul = 1'b1;
            ACT_CONJ:
            begin
                q_im = sat_fn(-PW'(acc_im_reg), s1);
                q_sat = s1;
            end
            ACT_POW:
            begin
                if (exponent == '0)
                begin
                    q_re = sat_fn(one_v, s1);
                    q_im = '0;
                    q_sat = s1;
                end
                else if (exponent != EXP_WIDTH'(1))
                    q_mul = 1'b1;
            end
            default: q_bad = 1'b1;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = q_mul ? ST_LOAD : ST_DONE;
            ST_LOAD: state_next = ST_MUL;
            ST_MUL:  if (last_bit) state_next = ST_FIX;
            ST_FIX:
            begin
                if (prod_reg == 2'd1 || prod_reg == 2'd3)
                    state_next = (prod_reg == 2'd3 && cnt_reg == EXP_WIDTH'(1)) ?
                                 ST_DONE : ST_LOAD;
                else
                    state_next = ST_MUL;
            end
            ST_DONE: if (!ov_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg  <= '0;
            acc_im_reg  <= '0;
            ov_reg      <= 1'b0;
            prod_reg    <= 2'd0;
            bit_reg     <= '0;
            cnt_reg     <= '0;
            sat_reg     <= 1'b0;
            res_bad_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        acc_re_reg  <= q_re;
                        acc_im_reg  <= q_im;
                        sat_reg     <= q_sat;
                        res_bad_reg <= q_bad;
                        prod_reg    <= 2'd0;
                        if (action == ACT_MUL)
                        begin
                            op_re_reg <= operand_real;
                            op_im_reg <= operand_imag;
                            cnt_reg   <= EXP_WIDTH'(1);
                        end
                        else
                        begin
                            op_re_reg <= acc_re_reg;
                            op_im_reg <= acc_im_reg;
                            cnt_reg   <= exponent - EXP_WIDTH'(1);
                        end
                    end
                end
                ST_LOAD:
                begin
                    sum_reg   <= '0;
                    part_reg  <= PW'(mcand);
                    mbits_reg <= mplier;
                    bit_reg   <= '0;
                end
                ST_MUL:
                begin
                    sum_reg   <= step_sum;
                    part_reg  <= part_reg <<< 1;
                    mbits_reg <= mbits_reg >> 1;
                    bit_reg   <= bit_reg + CW'(1);
                end
                ST_FIX:
                begin
                    // Products 1/3 close a part; after 0/2 load the next product
                    if (prod_reg == 2'd1 || prod_reg == 2'd3)
                    begin
                        if (prod_reg == 2'd1)
                        begin
                            pr_re_reg <= fix_val;
                            prod_reg  <= 2'd2;
                        end
                        else
                        begin
                            op_re_reg <= pr_re_reg;
                            op_im_reg <= fix_val;
                            prod_reg  <= 2'd0;
                            cnt_reg   <= cnt_reg - EXP_WIDTH'(1);
                            if (cnt_reg == EXP_WIDTH'(1))
                            begin
                                acc_re_reg <= pr_re_reg;
                                acc_im_reg <= fix_val;
                            end
                        end
                        sat_reg <= sat_reg | fix_sat;
                    end
                    else
                    begin
                        part_reg  <= PW'(mcand);
                        mbits_reg <= mplier;
                        bit_reg   <= '0;
                        prod_reg  <= prod_reg + 2'd1;
                    end
                end
                ST_DONE:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg      <= 1'b1;
                        res_re_reg  <= acc_re_reg;
                        res_im_reg  <= acc_im_reg;
                        res_sat_reg <= sat_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // ST_FIX consumes no bit: step_sum equals sum_reg
    // because mbits_reg was zeroed by the shifts, so the fix uses the full sum.

    `CAA_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE,
        "ready outside idle")
    `CAA_ASSERT_NXT(a_bad_nochange, clk, rst_n, in_fire && q_bad,
        acc_re_reg == $past(acc_re_reg) && acc_im_reg == $past(acc_im_reg),
        "invalid command changed accumulator")
    `CAA_ASSERT_IMP(a_bad_nosat, clk, rst_n, ov_reg && res_bad_reg, !res_sat_reg,
        "invalid command reported saturation")

endmodule

### bench/complex_accumulator_alu_unit_tb.sv
// ----------------------------------------------------------------------------
// complex_accumulator_alu_unit_tb
// Self-checking bench for the complex Q16.16 accumulator ALU. A directed
// table covers the extremes, every command and the saturation corners. A
// long random run follows and is checked against a bit-exact predictor of
// the accumulator, with bursty input traffic and a stalling output.
// ----------------------------------------------------------------------------
module complex_accumulator_alu_unit_tb;
    import caa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int EW = EXP_WIDTH_DEF;
    localparam logic [ACTION_WIDTH-1:0] ACT_BAD6 = 3'd6;
    localparam logic [ACTION_WIDTH-1:0] ACT_BAD7 = 3'd7;
    localparam int N_RANDOM    = 750;
    localparam longint LIMIT   = 6000000;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    typedef struct {
        logic [ACTION_WIDTH-1:0] act;
        logic signed [DW-1:0]    op_re;
        logic signed [DW-1:0]    op_im;
        logic [EW-1:0]           ex;
        bit                      known;
        logic signed [DW-1:0]    k_re;
        logic signed [DW-1:0]    k_im;
        bit                      k_bad;
        bit                      k_sat;
    } cmd_t;

    typedef struct {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        bit                   bad;
        bit                   sat;
    } acc_beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [ACTION_WIDTH-1:0] action;
    logic signed [DW-1:0] operand_real;
    logic signed [DW-1:0] operand_imag;
    logic [EW-1:0] exponent;
    logic out_valid;
    logic out_ready;
    logic signed [DW-1:0] value_real;
    logic signed [DW-1:0] value_imag;
    logic bad_command;
    logic saturated;

    // predictor state and expected results
    logic signed [DW-1:0] model_re;
    logic signed [DW-1:0] model_im;
    acc_beat_t pending_q[$];
    cmd_t      directed_rows[$];
    int        fail_count;
    int        beats_checked;
    int        sat_seen;
    int        big_pows;
    longint    cycle_count;

    complex_accumulator_alu_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .operand_real (operand_real),
        .operand_imag (operand_imag),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value_real   (value_real),
        .value_imag   (value_imag),
        .bad_command  (bad_command),
        .saturated    (saturated)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // clip to the data range, flagging any clipping
    function automatic logic signed [DW-1:0] clip(input logic signed [127:0] v, inout bit s);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = MAXV;
        lo = MINV;
        if (v > hi)
        begin
            s = 1'b1;
            return MAXV;
        end
        if (v < lo)
        begin
            s = 1'b1;
            return MINV;
        end
        return v[DW-1:0];
    endfunction

    // floored (a*c +/- b*d) >> FB, clipped
    function automatic logic signed [DW-1:0] fix_prod(input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] c, input logic signed [DW-1:0] b,
        input logic signed [DW-1:0] d, input bit negate, inout bit s);
        logic signed [127:0] p1;
        logic signed [127:0] p2;
        logic signed [127:0] sum;
        p1 = 128'(a) * 128'(c);
        p2 = 128'(b) * 128'(d);
        sum = negate ? p1 - p2 : p1 + p2;
        return clip(sum >>> FB, s);
    endfunction

    // complex multiply of (ar, ai) by (br, bi)
    task automatic cplx_mul(input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
        input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi,
        output logic signed [DW-1:0] pr, output logic signed [DW-1:0] pi, inout bit s);
        pr = fix_prod(ar, br, ai, bi, 1'b1, s);
        pi = fix_prod(ar, bi, ai, br, 1'b0, s);
    endtask

    // advance the accumulator model by one command
    task automatic step_accumulator(input cmd_t c, output acc_beat_t r);
        bit s;
        logic signed [DW-1:0] tr;
        logic signed [DW-1:0] ti;
        logic signed [DW-1:0] nr;
        logic signed [DW-1:0] ni;
        s = 1'b0;
        r.bad = 1'b0;
        case (c.act)
            ACT_CLEAR:
            begin
                model_re = '0;
                model_im = '0;
            end
            ACT_ADD:
            begin
                model_re = clip(128'(model_re) + 128'(c.op_re), s);
                model_im = clip(128'(model_im) + 128'(c.op_im), s);
            end
            ACT_SUB:
            begin
                model_re = clip(128'(model_re) - 128'(c.op_re), s);
                model_im = clip(128'(model_im) - 128'(c.op_im), s);
            end
            ACT_MUL:
            begin
                cplx_mul(model_re, model_im, c.op_re, c.op_im, nr, ni, s);
                model_re = nr;
                model_im = ni;
            end
            ACT_CONJ:
                model_im = clip(-128'(model_im), s);
            ACT_POW:
            begin
                if (c.ex == 0)
                begin
                    model_re = clip(128'(1) <<< FB, s);
                    model_im = '0;
                end
                else if (c.ex >= 2)
                begin
                    tr = model_re;
                    ti = model_im;
                    for (int k = 1; k < c.ex; k++)
                    begin
                        cplx_mul(model_re, model_im, tr, ti, nr, ni, s);
                        tr = nr;
                        ti = ni;
                    end
                    model_re = tr;
                    model_im = ti;
                end
            end
            default:
                r.bad = 1'b1;
        endcase
        r.re = model_re;
        r.im = model_im;
        r.sat = s;
    endtask

    // random operand: mostly near unit magnitude, sometimes an extreme, sometimes anything
    function automatic logic signed [DW-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 1) ? MAXV : MINV;
            default: return $signed($urandom_range(0, 32'h30000)) - 32'sh18000;
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)       c.act = ACT_CLEAR;
        else if (pick < 28) c.act = ACT_ADD;
        else if (pick < 43) c.act = ACT_SUB;
        else if (pick < 63) c.act = ACT_MUL;
        else if (pick < 73) c.act = ACT_CONJ;
        else if (pick < 90) c.act = ACT_POW;
        else                c.act = $urandom_range(0, 1) ? ACT_BAD6 : ACT_BAD7;
        c.op_re = rand_operand();
        c.op_im = rand_operand();
        c.ex = $urandom;
        // long power chains are slow, keep most exponents short
        if (c.act == ACT_POW)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 90)      c.ex = $urandom_range(0, 6);
            else if (pick < 98) c.ex = $urandom_range(7, 20);
        end
        c.known = 1'b0;
        return c;
    endfunction

    // send one beat, gap already handled by caller
    task automatic send_beat(input cmd_t c);
        acc_beat_t r;
        action       <= c.act;
        operand_real <= c.op_re;
        operand_imag <= c.op_im;
        exponent     <= c.ex;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        step_accumulator(c, r);
        if (c.known)
        begin
            r.re  = c.k_re;
            r.im  = c.k_im;
            r.bad = c.k_bad;
            r.sat = c.k_sat;
        end
        if (c.act == ACT_POW && c.ex > 20)
            big_pows++;
        pending_q.push_back(r);
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        int burst_left;
        int gap;
        cmd_t c;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_CLEAR;
        operand_real = '0;
        operand_imag = '0;
        exponent     = '0;
        model_re     = '0;
        model_im     = '0;
        fail_count   = 0;
        beats_checked = 0;
        sat_seen     = 0;
        big_pows     = 0;
        burst_left   = 0;

        // directed table: act, re, im, exp, known, exp re, exp im, bad, sat
        directed_rows.push_back('{ACT_CLEAR, 32'h1234, 32'h5678, 8'h00, 1, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_ADD, MAXV, MAXV, 8'hff, 1, MAXV, MAXV, 0, 0});
        directed_rows.push_back('{ACT_ADD, 1, 1, 8'h00, 1, MAXV, MAXV, 0, 1});
        directed_rows.push_back('{ACT_SUB, -1, -1, 8'h00, 1, MAXV, MAXV, 0, 1});
        directed_rows.push_back('{ACT_BAD6, MINV, MINV, 8'h55, 1, MAXV, MAXV, 1, 0});
        directed_rows.push_back('{ACT_BAD7, 32'h2, 32'h3, 8'haa, 1, MAXV, MAXV, 1, 0});
        directed_rows.push_back('{ACT_CLEAR, MAXV, MINV, 8'hff, 1, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_SUB, MAXV, MINV, 8'h00, 1, MINV + 1, MAXV, 0, 1});
        directed_rows.push_back('{ACT_ADD, MINV, MINV, 8'h00, 1, MINV, -1, 0, 1});
        directed_rows.push_back('{ACT_CONJ, 32'h7, 32'h9, 8'h00, 1, MINV, 1, 0, 0});
        directed_rows.push_back('{ACT_POW, MAXV, MAXV, 8'h01, 1, MINV, 1, 0, 0});
        directed_rows.push_back('{ACT_POW, 32'h0, 32'h0, 8'h00, 1, 32'h10000, 0, 0, 0});
        directed_rows.push_back('{ACT_CLEAR, 32'h0, 32'h0, 8'h00, 1, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_ADD, 32'h0, MINV, 8'h00, 1, 0, MINV, 0, 0});
        directed_rows.push_back('{ACT_CONJ, 32'h0, 32'h0, 8'h00, 1, 0, MAXV, 0, 1});
        directed_rows.push_back('{ACT_ADD, 32'h10000, 32'h0, 8'h00, 0, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_MUL, MAXV, MINV, 8'h00, 0, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_CLEAR, 32'h0, 32'h0, 8'h00, 1, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_ADD, 32'h18000, 32'h8000, 8'h00, 0, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_MUL, 32'h10000, 32'h10000, 8'h00, 0, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_POW, 32'h0, 32'h0, 8'h03, 0, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_MUL, -32'sh10000, 32'h0, 8'h00, 0, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_POW, 32'h0, 32'h0, 8'hff, 0, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_SUB, MINV, MAXV, 8'h00, 0, 0, 0, 0, 0});
        directed_rows.push_back('{ACT_POW, 32'h0, 32'h0, 8'h02, 0, 0, 0, 0, 0});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, back to back
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        // random part in bursts
        for (int n = 0; n < N_RANDOM; n++)
        begin
            // drain once mid-run before continuing
            if (n == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                while (pending_q.size() != 0)
                    @(negedge clk);
                burst_left = 0;
            end
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 40);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            c = rand_cmd();
            send_beat(c);
        end
        in_valid <= 1'b0;

        // drain and settle
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Checked %0d result beats (%0d saturated), %0d long power chains.",
                 beats_checked, sat_seen, big_pows);
        if (fail_count == 0)
            $display("complex_accumulator_alu_unit_tb passed");
        else
            $display("complex_accumulator_alu_unit_tb failed");
        $finish;
    end

    // receiver stall pattern: free, light or heavy, re-picked at random as cycle_count advances
    initial
    begin
        int mode;
        out_ready = 1'b0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if ((cycle_count % 64) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        acc_beat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected result beat: re %h im %h", value_real, value_imag);
                fail_count++;
            end
            else
            begin
                e = pending_q.pop_front();
                beats_checked++;
                if (saturated)
                    sat_seen++;
                if (value_real !== e.re)
                begin
                    $error("value_real: expected %h, got %h", e.re, value_real);
                    fail_count++;
                end
                if (value_imag !== e.im)
                begin
                    $error("value_imag: expected %h, got %h", e.im, value_imag);
                    fail_count++;
                end
                if (bad_command !== e.bad)
                begin
                    $error("bad_command: expected %b, got %b", e.bad, bad_command);
                    fail_count++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated: expected %b, got %b", e.sat, saturated);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d beats still pending.",
                 cycle_count, pending_q.size());
        $display("complex_accumulator_alu_unit_tb failed");
        $finish;
    end

endmodule
